/* sv/plob_pkg.sv */
// Shared types and constants for the price-level order book.
`default_nettype none
package plob_pkg;

  // Levels per side and derived widths
  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CFG_W = 5;
  localparam int unsigned LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned SIZE_W = 32;

  localparam logic [CFG_W-1:0] MAX_LEVELS_RESET = CFG_W'(10);

  // Action codes
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // Status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_MISSING   = 2'd2
  } status_e;

  // Command broadcast to every cell of a side
  typedef struct packed {
    logic               ins;
    logic               upd;
    logic               rem;
    logic               ask;
    logic [PRICE_W-1:0] price;
    logic [SIZE_W-1:0]  size;
  } cmd_t;

  // What a side reports back to the top
  typedef struct packed {
    logic               found;
    logic               nonempty;
    logic [PRICE_W-1:0] best_price;
    logic [SIZE_W-1:0]  best_size;
  } side_sts_t;

endpackage
`default_nettype wire

/* sv/plob_cell.sv */
// One price level cell: holds a price and size, shifts with its neighbors.
`default_nettype none
module plob_cell (
  input  wire logic                           clk_i,
  input  wire plob_pkg::cmd_t                 cmd_i,
  input  wire logic                           en_i,
  input  wire logic                           found_i,
  input  wire logic                           occ_i,
  input  wire logic                           ge_prev_i,
  input  wire logic [plob_pkg::PRICE_W-1:0]   left_price_i,
  input  wire logic [plob_pkg::SIZE_W-1:0]    left_size_i,
  input  wire logic [plob_pkg::PRICE_W-1:0]   right_price_i,
  input  wire logic [plob_pkg::SIZE_W-1:0]    right_size_i,
  output logic                                match_o,
  output logic                                ge_o,
  output logic [plob_pkg::PRICE_W-1:0]        price_o,
  output logic [plob_pkg::SIZE_W-1:0]         size_o
);

  logic [plob_pkg::PRICE_W-1:0] price_q, price_d;
  logic [plob_pkg::SIZE_W-1:0]  size_q, size_d;
  logic                         ahead;

  // Local compares against the broadcast price
  assign match_o = occ_i && (price_q == cmd_i.price);
  assign ahead   = cmd_i.ask ? (cmd_i.price < price_q) : (cmd_i.price > price_q);
  // At or past the insert point; free cells count as past it
  assign ge_o    = !occ_i || ahead;

  always_comb begin
    price_d = price_q;
    size_d  = size_q;
    if (en_i && cmd_i.ins && !found_i) begin
      if (ge_prev_i) begin
        price_d = left_price_i;
        size_d  = left_size_i;
      end else if (ge_o) begin
        price_d = cmd_i.price;
        size_d  = cmd_i.size;
      end
    end else if (en_i && cmd_i.upd && match_o) begin
      size_d = cmd_i.size;
    end else if (en_i && cmd_i.rem && found_i && occ_i && (ahead || match_o)) begin
      // At or behind the removed level: pull from the right
      price_d = right_price_i;
      size_d  = right_size_i;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    size_q  <= size_d;
  end

  assign price_o = price_q;
  assign size_o  = size_q;

endmodule
`default_nettype wire

/* sv/plob_side.sv */
// One side of the book: a row of level cells and the level count.
`default_nettype none
module plob_side (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire plob_pkg::cmd_t               cmd_i,
  input  wire logic                         en_i,
  input  wire logic [plob_pkg::CNT_W-1:0]   lim_i,
  output plob_pkg::side_sts_t               sts_o
);

  localparam int unsigned D = plob_pkg::DEPTH;

  logic [plob_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [D-1:0]                 match, ge, occ;
  logic [plob_pkg::PRICE_W-1:0] price [D];
  logic [plob_pkg::SIZE_W-1:0]  size  [D];
  logic                         found;
  logic [plob_pkg::CNT_W:0]     cnt_inc;

  assign found = |match;

  // Row of cells, each wired to both neighbors
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic                         ge_prev;
    logic [plob_pkg::PRICE_W-1:0] lp, rp;
    logic [plob_pkg::SIZE_W-1:0]  ls, rs;

    assign occ[i] = plob_pkg::CNT_W'(i) < cnt_q;

    if (i == 0) begin : g_first
      assign ge_prev = 1'b0;
      assign lp      = price[i];
      assign ls      = size[i];
    end else begin : g_mid
      assign ge_prev = ge[i-1];
      assign lp      = price[i-1];
      assign ls      = size[i-1];
    end

    if (i == D - 1) begin : g_last
      assign rp = price[i];
      assign rs = size[i];
    end else begin : g_inner
      assign rp = price[i+1];
      assign rs = size[i+1];
    end

    plob_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd_i),
      .en_i          (en_i),
      .found_i       (found),
      .occ_i         (occ[i]),
      .ge_prev_i     (ge_prev),
      .left_price_i  (lp),
      .left_size_i   (ls),
      .right_price_i (rp),
      .right_size_i  (rs),
      .match_o       (match[i]),
      .ge_o          (ge[i]),
      .price_o       (price[i]),
      .size_o        (size[i])
    );
  end

  // Level count: grow on insert, capped at the limit (which can trim it), shrink on remove
  assign cnt_inc = {1'b0, cnt_q} + 1'b1;

  always_comb begin
    cnt_d = cnt_q;
    if (en_i && cmd_i.ins && !found) begin
      if (cnt_inc > {1'b0, lim_i}) cnt_d = lim_i;
      else                         cnt_d = cnt_inc[plob_pkg::CNT_W-1:0];
    end else if (en_i && cmd_i.rem && found) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign sts_o.found      = found;
  assign sts_o.nonempty   = (cnt_q != '0);
  assign sts_o.best_price = (cnt_q != '0) ? price[0] : '0;
  assign sts_o.best_size  = (cnt_q != '0) ? size[0] : '0;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= plob_pkg::CNT_W'(D))
    else $error("level count above depth");

  a_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("price present in more than one level");

  a_rem_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && cmd_i.rem && found |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("remove did not drop the count");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(cnt_q))
    else $error("count moved without a command");

endmodule
`default_nettype wire

/* sv/price_level_order_book_top.sv */
// Top level of the price-level order book: command decode, limit register, result.
//
//  channel   ports                                     handshake
//  -------   ---------------------------------------   ---------------------------
//  command   action_i side_i price_i size_i            start_i high, busy_o low
//  result    best_*_o status_o level_found_o           done_o strobe, one cycle
//  config    cfg_data_i (max_levels)                   cfg_we_i high
//
// A command is taken in any cycle; busy_o stays low. All level cells compare
// the price in parallel and shift in the accept cycle, so the result strobe
// follows in the cycle after each accepted beat and one beat per cycle is sustained.
// Reset empties both sides and loads max_levels with 10; level contents are
// not cleared. The receiver cannot stall results.
`default_nettype none
module price_level_order_book_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [1:0]                    action_i,
  input  wire logic                          side_i,
  input  wire logic [plob_pkg::PRICE_W-1:0]  price_i,
  input  wire logic [plob_pkg::SIZE_W-1:0]   size_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [plob_pkg::CFG_W-1:0]    cfg_data_i,
  output logic                               done_o,
  output logic [plob_pkg::PRICE_W-1:0]       best_bid_price_o,
  output logic [plob_pkg::SIZE_W-1:0]        best_bid_size_o,
  output logic [plob_pkg::PRICE_W-1:0]       best_ask_price_o,
  output logic [plob_pkg::SIZE_W-1:0]        best_ask_size_o,
  output logic [1:0]                         status_o,
  output logic                               level_found_o
);

  logic [plob_pkg::CFG_W-1:0] maxlev_q;
  logic [plob_pkg::LIM_W-1:0] lim_w;
  logic [plob_pkg::CNT_W-1:0] lim;
  plob_pkg::cmd_t             cmd;
  plob_pkg::side_sts_t        bid_sts, ask_sts;
  plob_pkg::action_e          act;
  logic                       accept, found_sel;
  logic                       done_q, found_q;
  plob_pkg::status_e          status_q, status_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign act    = plob_pkg::action_e'(action_i);

  // Effective limit: zero acts as one, clamp to depth
  always_comb begin
    lim_w = plob_pkg::LIM_W'(maxlev_q);
    if (lim_w == '0) lim_w = plob_pkg::LIM_W'(1);
    if (lim_w > plob_pkg::LIM_W'(plob_pkg::DEPTH)) lim_w = plob_pkg::LIM_W'(plob_pkg::DEPTH);
  end
  assign lim = lim_w[plob_pkg::CNT_W-1:0];

  // Command decode
  assign cmd.ins   = (act == plob_pkg::ACT_INSERT);
  assign cmd.upd   = (act == plob_pkg::ACT_UPDATE);
  assign cmd.rem   = (act == plob_pkg::ACT_REMOVE);
  assign cmd.ask   = side_i;
  assign cmd.price = price_i;
  assign cmd.size  = size_i;

  plob_side u_bid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .en_i   (accept && !side_i),
    .lim_i  (lim),
    .sts_o  (bid_sts)
  );

  plob_side u_ask (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .en_i   (accept && side_i),
    .lim_i  (lim),
    .sts_o  (ask_sts)
  );

  assign found_sel = side_i ? ask_sts.found : bid_sts.found;

  // Status of the accepted beat
  always_comb begin
    case (act)
      plob_pkg::ACT_INSERT: status_d = found_sel ? plob_pkg::ST_DUPLICATE : plob_pkg::ST_DONE;
      plob_pkg::ACT_UPDATE,
      plob_pkg::ACT_REMOVE: status_d = found_sel ? plob_pkg::ST_DONE : plob_pkg::ST_MISSING;
      default:              status_d = plob_pkg::ST_DONE;
    endcase
  end

  // Limit register and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxlev_q <= plob_pkg::MAX_LEVELS_RESET;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) maxlev_q <= cfg_data_i;
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      found_q  <= found_sel;
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign level_found_o    = found_q;
  assign best_bid_price_o = bid_sts.best_price;
  assign best_bid_size_o  = bid_sts.best_size;
  assign best_ask_price_o = ask_sts.best_price;
  assign best_ask_size_o  = ask_sts.best_size;

  // Checks
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted beat gave no result");

  a_dup_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == plob_pkg::ST_DUPLICATE |-> level_found_o)
    else $error("duplicate status without a found level");

  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == plob_pkg::ST_MISSING |-> !level_found_o)
    else $error("missing status with a found level");

endmodule
`default_nettype wire

/* bench/tb_price_level_order_book_top.sv */
// Self-checking bench for the price-level order book: predicted top of book vs. DUT output.
`timescale 1ns / 100ps

module tb_price_level_order_book_top;

  // Top of book plus status, as carried by one result beat
  typedef struct packed {
    logic [plob_pkg::PRICE_W-1:0] bid_px;
    logic [plob_pkg::SIZE_W-1:0]  bid_sz;
    logic [plob_pkg::PRICE_W-1:0] ask_px;
    logic [plob_pkg::SIZE_W-1:0]  ask_sz;
    plob_pkg::status_e            st;
    logic                         found;
  } book_top_t;

  // Shadow book per side (0 bid, 1 ask) and the queue of predicted tops
  class top_of_book_sb;
    logic [plob_pkg::PRICE_W-1:0] lvl_px[2][plob_pkg::DEPTH];
    logic [plob_pkg::SIZE_W-1:0]  lvl_sz[2][plob_pkg::DEPTH];
    int                           lvl_n[2];
    int                           lim;
    book_top_t                    expected_tops[$];
    int                           errors;
    int                           n_cmds;
    int                           n_results;
    int                           n_dup;
    int                           n_missing;
    int                           n_limits;

    function new();
      lvl_n[0] = 0;
      lvl_n[1] = 0;
      lim = int'(plob_pkg::MAX_LEVELS_RESET);
    endfunction

    // Register write: 0 behaves as 1, anything above DEPTH as DEPTH
    function void set_limit(logic [plob_pkg::CFG_W-1:0] v);
      lim = (v == 0) ? 1 : (v > plob_pkg::DEPTH) ? plob_pkg::DEPTH : int'(v);
      n_limits++;
    endfunction

    // Apply one accepted command to the shadow book and queue the resulting top
    function void note_command(plob_pkg::action_e act, logic ask,
                               logic [plob_pkg::PRICE_W-1:0] px,
                               logic [plob_pkg::SIZE_W-1:0] sz);
      int                sd;
      int                n;
      int                idx;
      int                pos;
      bit                hit;
      plob_pkg::status_e st;
      book_top_t         e;
      sd  = ask ? 1 : 0;
      n   = lvl_n[sd];
      hit = 1'b0;
      idx = 0;
      st  = plob_pkg::ST_DONE;
      for (int i = 0; i < n; i++) begin
        if (!hit && lvl_px[sd][i] == px) begin
          hit = 1'b1;
          idx = i;
        end
      end
      case (act)
        plob_pkg::ACT_INSERT: begin
          if (hit) begin
            st = plob_pkg::ST_DUPLICATE;
          end else begin
            // first level the new price ranks ahead of
            pos = n;
            for (int i = 0; i < n; i++) begin
              if (pos == n && (ask ? (px < lvl_px[sd][i]) : (px > lvl_px[sd][i])))
                pos = i;
            end
            for (int i = n; i > pos; i--) begin
              if (i < plob_pkg::DEPTH) begin
                lvl_px[sd][i] = lvl_px[sd][i-1];
                lvl_sz[sd][i] = lvl_sz[sd][i-1];
              end
            end
            if (pos < plob_pkg::DEPTH) begin
              lvl_px[sd][pos] = px;
              lvl_sz[sd][pos] = sz;
            end
            // worst levels fall off beyond the limit
            lvl_n[sd] = (n + 1 > lim) ? lim : n + 1;
          end
        end
        plob_pkg::ACT_UPDATE: begin
          if (hit) lvl_sz[sd][idx] = sz;
          else st = plob_pkg::ST_MISSING;
        end
        plob_pkg::ACT_REMOVE: begin
          if (hit) begin
            for (int i = idx; i + 1 < n; i++) begin
              lvl_px[sd][i] = lvl_px[sd][i+1];
              lvl_sz[sd][i] = lvl_sz[sd][i+1];
            end
            lvl_n[sd] = n - 1;
          end else begin
            st = plob_pkg::ST_MISSING;
          end
        end
        default: ;
      endcase
      e.bid_px = lvl_n[0] ? lvl_px[0][0] : '0;
      e.bid_sz = lvl_n[0] ? lvl_sz[0][0] : '0;
      e.ask_px = lvl_n[1] ? lvl_px[1][0] : '0;
      e.ask_sz = lvl_n[1] ? lvl_sz[1][0] : '0;
      e.st     = st;
      e.found  = hit;
      if (st == plob_pkg::ST_DUPLICATE) n_dup++;
      if (st == plob_pkg::ST_MISSING) n_missing++;
      n_cmds++;
      expected_tops.push_back(e);
    endfunction

    function void flag_error();
      errors++;
    endfunction

    // Compare one result beat with the oldest prediction
    function void check_result(book_top_t got);
      book_top_t e;
      n_results++;
      if (expected_tops.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch %0d: result beat with no command outstanding", errors);
      end else begin
        e = expected_tops.pop_front();
        if (got !== e) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch %0d: exp bid %h/%h ask %h/%h st %0d found %b",
                     errors, e.bid_px, e.bid_sz, e.ask_px, e.ask_sz, e.st, e.found);
            $display("             got bid %h/%h ask %h/%h st %0d found %b",
                     got.bid_px, got.bid_sz, got.ask_px, got.ask_sz, got.st, got.found);
          end
        end
      end
    endfunction

    function int pending();
      return expected_tops.size();
    endfunction
  endclass

  localparam int QUIET_LIMIT = 500;

  logic                           clk_i      = 1'b0;
  logic                           rst_ni     = 1'b0;
  logic                           start_i    = 1'b0;
  logic [1:0]                     action_i   = '0;
  logic                           side_i     = 1'b0;
  logic [plob_pkg::PRICE_W-1:0]   price_i    = '0;
  logic [plob_pkg::SIZE_W-1:0]    size_i     = '0;
  logic                           cfg_we_i   = 1'b0;
  logic [plob_pkg::CFG_W-1:0]     cfg_data_i = '0;
  wire                            busy_o;
  wire                            done_o;
  wire [plob_pkg::PRICE_W-1:0]    best_bid_price_o;
  wire [plob_pkg::SIZE_W-1:0]     best_bid_size_o;
  wire [plob_pkg::PRICE_W-1:0]    best_ask_price_o;
  wire [plob_pkg::SIZE_W-1:0]     best_ask_size_o;
  wire [1:0]                      status_o;
  wire                            level_found_o;

  top_of_book_sb sb;
  bit            gaps_on;
  int            quiet_cycles;

  price_level_order_book_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .action_i         (action_i),
    .side_i           (side_i),
    .price_i          (price_i),
    .size_i           (size_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .best_bid_price_o (best_bid_price_o),
    .best_bid_size_o  (best_bid_size_o),
    .best_ask_price_o (best_ask_price_o),
    .best_ask_size_o  (best_ask_size_o),
    .status_o         (status_o),
    .level_found_o    (level_found_o)
  );

  always #2 clk_i = ~clk_i;

  // Monitor: result beat checked before the command beat of the same edge is noted
  always @(posedge clk_i) begin
    book_top_t got;
    if (rst_ni) begin
      if (done_o) begin
        got.bid_px = best_bid_price_o;
        got.bid_sz = best_bid_size_o;
        got.ask_px = best_ask_price_o;
        got.ask_sz = best_ask_size_o;
        got.st     = plob_pkg::status_e'(status_o);
        got.found  = level_found_o;
        sb.check_result(got);
      end
      if (start_i && !busy_o)
        sb.note_command(plob_pkg::action_e'(action_i), side_i, price_i, size_i);
      if (cfg_we_i)
        sb.set_limit(cfg_data_i);
    end
  end

  // Watchdog: too long without any beat or register write
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o || (start_i && !busy_o) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no activity for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // One command beat, with optional idle cycles ahead of it
  task automatic send_cmd(input plob_pkg::action_e act, input logic ask,
                          input logic [plob_pkg::PRICE_W-1:0] px,
                          input logic [plob_pkg::SIZE_W-1:0] sz);
    // each cycle idles with a 29 percent chance
    while (gaps_on && $urandom_range(0, 99) < 29) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i  <= 1'b1;
    action_i <= act;
    side_i   <= ask;
    price_i  <= px;
    size_i   <= sz;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [plob_pkg::CFG_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random traffic: mostly prices from a small pool so updates and removes hit
  task automatic random_phase(input int items);
    logic [plob_pkg::PRICE_W-1:0] pool[20];
    logic [plob_pkg::PRICE_W-1:0] base;
    logic [plob_pkg::PRICE_W-1:0] px;
    logic [plob_pkg::SIZE_W-1:0]  sz;
    plob_pkg::action_e            act;
    int                           r;
    pool[0] = '0;
    pool[1] = '1;
    pool[2] = 32'd1;
    pool[3] = 32'hFFFF_FFFE;
    base    = $urandom;
    for (int k = 4; k < 12; k++) pool[k] = base + $urandom_range(0, 16);
    for (int k = 12; k < 20; k++) pool[k] = $urandom;
    for (int n = 0; n < items; n++) begin
      r  = $urandom_range(0, 99);
      px = pool[$urandom_range(0, 19)];
      if (r < 45) act = plob_pkg::ACT_INSERT;
      else if (r < 65) act = plob_pkg::ACT_UPDATE;
      else if (r < 92) act = plob_pkg::ACT_REMOVE;
      else if (r < 95) act = plob_pkg::ACT_NONE;
      else begin
        // noise: any code, any price
        act = plob_pkg::action_e'($urandom_range(0, 3));
        px  = $urandom;
      end
      r = $urandom_range(0, 99);
      sz = (r < 5) ? '0 : (r < 10) ? '1 : plob_pkg::SIZE_W'($urandom);
      send_cmd(act, 1'($urandom_range(0, 1)), px, sz);
    end
    drain();
  endtask

  initial begin
    sb = new();
    gaps_on = 1'b1;
    quiet_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty book, extreme prices and sizes, every action and status
    send_cmd(plob_pkg::ACT_REMOVE, 1'b0, 32'h0000_0000, 32'h0);
    send_cmd(plob_pkg::ACT_UPDATE, 1'b1, 32'hFFFF_FFFF, 32'h1);
    send_cmd(plob_pkg::ACT_INSERT, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(plob_pkg::ACT_INSERT, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(plob_pkg::ACT_INSERT, 1'b0, 32'h8000_0000, 32'h1234_5678);
    send_cmd(plob_pkg::ACT_INSERT, 1'b0, 32'hFFFF_FFFF, 32'h5555_5555);
    send_cmd(plob_pkg::ACT_INSERT, 1'b1, 32'hFFFF_FFFF, 32'h0000_0001);
    send_cmd(plob_pkg::ACT_INSERT, 1'b1, 32'h0000_0000, 32'hA5A5_A5A5);
    send_cmd(plob_pkg::ACT_INSERT, 1'b1, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
    send_cmd(plob_pkg::ACT_UPDATE, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(plob_pkg::ACT_UPDATE, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    send_cmd(plob_pkg::ACT_NONE,   1'b0, 32'hFFFF_FFFF, 32'hDEAD_BEEF);
    send_cmd(plob_pkg::ACT_NONE,   1'b1, 32'h0000_1234, 32'h0);
    send_cmd(plob_pkg::ACT_REMOVE, 1'b1, 32'h0000_0000, 32'h0);
    send_cmd(plob_pkg::ACT_REMOVE, 1'b0, 32'h8000_0000, 32'h0);
    send_cmd(plob_pkg::ACT_INSERT, 1'b1, 32'hFFFF_FFFF, 32'h7);
    drain();

    // Limit below the current count: the next insert trims to the best level
    write_limit(5'd1);
    send_cmd(plob_pkg::ACT_INSERT, 1'b0, 32'h0000_0005, 32'h11);
    send_cmd(plob_pkg::ACT_INSERT, 1'b1, 32'hFFFF_FFF0, 32'h22);
    send_cmd(plob_pkg::ACT_INSERT, 1'b1, 32'h0000_0001, 32'h33);
    send_cmd(plob_pkg::ACT_REMOVE, 1'b1, 32'h0000_0001, 32'h0);
    send_cmd(plob_pkg::ACT_REMOVE, 1'b0, 32'hFFFF_FFFF, 32'h0);
    drain();

    // Random phases over a spread of limits, two of them without idle gaps
    write_limit(5'd16);
    random_phase(215);
    write_limit(5'd0);
    random_phase(215);
    gaps_on = 1'b0;
    write_limit(5'd31);
    random_phase(215);
    write_limit(5'd3);
    random_phase(215);
    gaps_on = 1'b1;
    write_limit(5'($urandom_range(2, 15)));
    random_phase(215);
    write_limit(5'd1);
    random_phase(215);
    write_limit(5'($urandom_range(17, 30)));
    random_phase(215);
    write_limit(5'd10);
    random_phase(215);
    write_limit(5'($urandom_range(0, 31)));
    random_phase(215);

    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.flag_error();
      $display("%0d predicted results never arrived", sb.pending());
    end
    $display("run: %0d commands, %0d results, %0d limit writes",
             sb.n_cmds, sb.n_results, sb.n_limits);
    $display("     %0d duplicate inserts, %0d missing levels, %0d mismatches",
             sb.n_dup, sb.n_missing, sb.errors);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/plob_pkg.sv
sv/plob_cell.sv
sv/plob_side.sv
sv/price_level_order_book_top.sv
bench/tb_price_level_order_book_top.sv
